// ===== design/bnms_pkg.sv =====
// Shared types, register map and helpers for the box suppression block.
// No dependencies; imported by bnms_iou, the top level and the testbench.
package bnms_pkg;

    typedef struct packed {
        logic signed [17:0] left;
        logic signed [17:0] top;
        logic signed [17:0] right;
        logic signed [17:0] bottom;
    } t_box;

    // one candidate list entry, as stored in the candidate RAM
    typedef struct packed {
        t_box        box;
        logic [15:0] score;
        logic [11:0] number;
    } t_cand;

    typedef struct packed {
        logic        has_box;
        logic [11:0] number;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic [15:0] score;
    } t_result;

    // IoU unit status back to the sequencer
    typedef struct packed {
        logic done;
        logic suppress;
    } t_iou_stat;

    localparam logic [2:0] REG_SCORE_THR   = 3'd0;
    localparam logic [2:0] REG_OVERLAP_THR = 3'd1;
    localparam logic [2:0] REG_CAND_LIMIT  = 3'd2;
    localparam logic [2:0] REG_KEEP_LIMIT  = 3'd3;
    localparam logic [2:0] REG_REPORT_THR  = 3'd4;
    localparam logic [2:0] REG_REGION_W    = 3'd5;
    localparam logic [2:0] REG_REGION_H    = 3'd6;

    // positive extent hi - lo, zero when empty
    function automatic logic [17:0] f_span(input logic signed [17:0] lo,
                                           input logic signed [17:0] hi);
        logic signed [18:0] d;
        d = 19'(hi) - 19'(lo);
        return (hi > lo) ? d[17:0] : 18'd0;
    endfunction

endpackage

// ===== design/bnms_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bnms_ram #(
    parameter int W  = 8,
    parameter int D  = 64,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/bnms_iou.sv =====
// Five-stage IoU overlap test: spans, areas, union, threshold products, compare.
// Depends on bnms_pkg.
module bnms_iou (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  bnms_pkg::t_box       i_a,
    input  bnms_pkg::t_box       i_b,
    input  logic [15:0]          i_thr,
    output bnms_pkg::t_iou_stat  o_stat
);
    import bnms_pkg::*;

    logic signed [17:0] il, ir, it, ib;
    logic [17:0] r_w1, r_h1, r_w2, r_h2, r_iw, r_ih;
    logic [35:0] r_a1, r_a2, r_in2;
    logic [36:0] r_uni;
    logic [35:0] r_in3, r_in4;
    logic [33:0] r_pl;
    logic [34:0] r_ph;
    logic        r_sup;
    logic [4:0]  r_v;

    assign il = (i_a.left > i_b.left) ? i_a.left : i_b.left;
    assign ir = (i_a.right < i_b.right) ? i_a.right : i_b.right;
    assign it = (i_a.top > i_b.top) ? i_a.top : i_b.top;
    assign ib = (i_a.bottom < i_b.bottom) ? i_a.bottom : i_b.bottom;

    always_ff @(posedge i_clk) begin
        // stage 1: extents
        r_w1 <= f_span(i_a.left, i_a.right);
        r_h1 <= f_span(i_a.top, i_a.bottom);
        r_w2 <= f_span(i_b.left, i_b.right);
        r_h2 <= f_span(i_b.top, i_b.bottom);
        r_iw <= f_span(il, ir);
        r_ih <= f_span(it, ib);
        // stage 2: areas
        r_a1  <= r_w1 * r_h1;
        r_a2  <= r_w2 * r_h2;
        r_in2 <= r_iw * r_ih;
        // stage 3: union
        r_uni <= 37'(r_a1) + 37'(r_a2) - 37'(r_in2);
        r_in3 <= r_in2;
        // stage 4: threshold times union, split in two halves
        r_pl  <= i_thr * r_uni[17:0];
        r_ph  <= i_thr * r_uni[36:18];
        r_in4 <= r_in3;
        // stage 5: inter * 2^16 > thr * union
        r_sup <= 53'({r_in4, 16'd0}) > ({r_ph, 18'd0} + 53'(r_pl));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_start};
        end
    end

    assign o_stat.done     = r_v[4];
    assign o_stat.suppress = r_sup;
endmodule

// ===== design/box_non_max_suppression.sv =====
// Top level of the greedy box suppression block: APB registers, sequencer,
// candidate and kept-slot RAMs. Depends on bnms_pkg, bnms_ram, bnms_iou.
//
// Boxes are taken one per start pulse while busy is low; frame_end marks a
// frame's last box. A box scoring above the score threshold is inserted into
// a score-sorted candidate list held in a single-port-read RAM, a full list
// taking it only if it outscores the tail entry: the sequencer walks from the
// list's tail, moving entries one place down until the box's place is found.
// At frame end every candidate is checked against the boxes already kept;
// each check reads the kept-slot RAM, then the candidate RAM, then runs the
// five-stage IoU unit. Results come out one per o_valid pulse and cannot be
// held off: the receiver must take each on the cycle it is shown. The last
// result of a frame has o_run_last set; a frame with nothing to report gives
// a single result with o_has_box low. busy rises the cycle after an item is
// taken, unless the item is dropped and does not end a frame, and falls when a
// mid-frame insertion ends or in the cycle that shows the frame's last result,
// so the next item can be taken at the edge that ends that cycle.
module box_non_max_suppression #(
    parameter int MAX_CAND   = 64,
    parameter int MAX_BOXES  = 4096,
    parameter int COORD_FRAC = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item port
    input  logic               start,
    output logic               busy,
    input  logic signed [17:0] i_left_edge,
    input  logic signed [17:0] i_top_edge,
    input  logic signed [17:0] i_right_edge,
    input  logic signed [17:0] i_bottom_edge,
    input  logic [15:0]        i_box_score,
    input  logic               i_frame_end,
    // result port
    output logic               o_valid,
    output logic               o_has_box,
    output logic [11:0]        o_box_number,
    output logic [15:0]        o_out_left,
    output logic [15:0]        o_out_top,
    output logic [15:0]        o_out_right,
    output logic [15:0]        o_out_bottom,
    output logic [15:0]        o_out_score,
    output logic               o_run_last,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bnms_pkg::*;

    localparam int IW  = (MAX_CAND > 1) ? $clog2(MAX_CAND) : 1;
    localparam int CW  = $clog2(MAX_CAND + 1);
    localparam int AW  = $clog2(MAX_BOXES);
    localparam int CLW = COORD_FRAC + 1;
    localparam int SW  = CLW + 12;
    localparam int ONE_I = 1 << COORD_FRAC;
    localparam logic [SW-1:0] RND = SW'(1) << (COORD_FRAC - 5);

    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_INS_RD   = 14'b00000000000010,
        ST_INS_CMP  = 14'b00000000000100,
        ST_SUP_RD   = 14'b00000000001000,
        ST_SUP_LD   = 14'b00000000010000,
        ST_KEEP_RD  = 14'b00000000100000,
        ST_SLOT_RD  = 14'b00000001000000,
        ST_IOU_GO   = 14'b00000010000000,
        ST_IOU_WAIT = 14'b00000100000000,
        ST_OUT_RD   = 14'b00001000000000,
        ST_OUT_SLOT = 14'b00010000000000,
        ST_OUT_CALC = 14'b00100000000000,
        ST_FIN      = 14'b01000000000000,
        ST_SPARE    = 14'b10000000000000
    } t_state;

    // clip to [0,1] then scale to Q12.4 pixels, rounding halves up
    function automatic logic [15:0] f_scale(input logic signed [17:0] c,
                                            input logic [11:0] sz);
        logic [CLW-1:0] cc;
        logic [SW-1:0]  v;
        if (c < 0) begin
            cc = '0;
        end else if (int'(c) > ONE_I) begin
            cc = CLW'(ONE_I);
        end else begin
            cc = CLW'(c);
        end
        v = SW'(cc) * SW'(sz) + RND;
        return 16'(v >> (COORD_FRAC - 4));
    endfunction

    // registers
    logic [15:0] r_score_thr, r_overlap_thr, r_report_thr;
    logic [6:0]  r_cand_lim, r_keep_lim;
    logic [11:0] r_region_w, r_region_h;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cand_count, n_cand_count;
    logic [AW-1:0] r_arrival, n_arrival;
    logic [CW-1:0] r_kept, n_kept;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_q, n_q;
    logic          r_chk, n_chk;
    logic          r_fe, n_fe;
    t_cand         r_new, n_new;
    t_box          r_a, n_a;
    t_result       r_pend, n_pend;
    logic          r_pend_v, n_pend_v;
    t_result       r_o, n_o;
    logic          r_o_last, n_o_last;
    logic          r_o_valid, n_o_valid;
    logic          r_iou_start, n_iou_start;

    // RAM ports
    logic            cand_we;
    logic [IW-1:0]   cand_waddr, cand_raddr;
    t_cand           cand_wdata, cand_rd;
    logic [$bits(t_cand)-1:0] cand_rdata;
    logic            kept_we;
    logic [IW-1:0]   kept_waddr, kept_raddr, kept_wdata, kept_rd;

    t_iou_stat     iou_stat;

    logic          accept;
    logic [CW-1:0] lim, eff_n, ip;
    logic [6:0]    klim, kept7, out_n;
    logic [AW-1:0] arr_next;
    t_state        ins_done;
    t_result       new_res;

    // ---------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_thr   <= 16'd0;
            r_overlap_thr <= 16'd29491;
            r_cand_lim    <= 7'd64;
            r_keep_lim    <= 7'd64;
            r_report_thr  <= 16'd0;
            r_region_w    <= 12'd0;
            r_region_h    <= 12'd0;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_SCORE_THR:   r_score_thr   <= pwdata[15:0];
                REG_OVERLAP_THR: r_overlap_thr <= pwdata[15:0];
                REG_CAND_LIMIT:  r_cand_lim    <= pwdata[6:0];
                REG_KEEP_LIMIT:  r_keep_lim    <= pwdata[6:0];
                REG_REPORT_THR:  r_report_thr  <= pwdata[15:0];
                REG_REGION_W:    r_region_w    <= pwdata[11:0];
                REG_REGION_H:    r_region_h    <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_SCORE_THR:   prdata = 32'(r_score_thr);
            REG_OVERLAP_THR: prdata = 32'(r_overlap_thr);
            REG_CAND_LIMIT:  prdata = 32'(r_cand_lim);
            REG_KEEP_LIMIT:  prdata = 32'(r_keep_lim);
            REG_REPORT_THR:  prdata = 32'(r_report_thr);
            REG_REGION_W:    prdata = 32'(r_region_w);
            REG_REGION_H:    prdata = 32'(r_region_h);
            default:         prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Storage and IoU unit
    // ---------------------------------------------------------------
    bnms_ram #(.W($bits(t_cand)), .D(MAX_CAND), .AW(IW)) u_cand_ram (
        .i_clk   (i_clk),
        .i_we    (cand_we),
        .i_waddr (cand_waddr),
        .i_wdata (cand_wdata),
        .i_raddr (cand_raddr),
        .o_rdata (cand_rdata)
    );
    assign cand_rd = t_cand'(cand_rdata);

    // list positions of the boxes that survived so far
    bnms_ram #(.W(IW), .D(MAX_CAND), .AW(IW)) u_kept_ram (
        .i_clk   (i_clk),
        .i_we    (kept_we),
        .i_waddr (kept_waddr),
        .i_wdata (kept_wdata),
        .i_raddr (kept_raddr),
        .o_rdata (kept_rd)
    );

    bnms_iou u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_iou_start),
        .i_a     (r_a),
        .i_b     (cand_rd.box),
        .i_thr   (r_overlap_thr),
        .o_stat  (iou_stat)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // a lowered limit trims the lowest-ranked entries
    assign lim   = (r_cand_lim >= 7'(MAX_CAND)) ? CW'(MAX_CAND) : CW'(r_cand_lim);
    assign eff_n = (r_cand_count > lim) ? lim : r_cand_count;
    assign ip    = r_i - CW'(1);

    assign klim  = (r_keep_lim >= 7'd64) ? 7'd64 : r_keep_lim;
    assign kept7 = 7'(r_kept);
    assign out_n = (kept7 > klim) ? klim : kept7;

    assign arr_next = (r_arrival == AW'(MAX_BOXES - 1)) ? '0 : r_arrival + AW'(1);
    assign ins_done = r_fe ? ST_SUP_RD : ST_IDLE;

    always_comb begin
        new_res.has_box = 1'b1;
        new_res.number  = cand_rd.number;
        new_res.left    = f_scale(cand_rd.box.left, r_region_w);
        new_res.top     = f_scale(cand_rd.box.top, r_region_h);
        new_res.right   = f_scale(cand_rd.box.right, r_region_w);
        new_res.bottom  = f_scale(cand_rd.box.bottom, r_region_h);
        new_res.score   = cand_rd.score;
    end

    always_comb begin
        n_state      = r_state;
        n_cand_count = r_cand_count;
        n_arrival    = r_arrival;
        n_kept       = r_kept;
        n_i          = r_i;
        n_j          = r_j;
        n_q          = r_q;
        n_chk        = r_chk;
        n_fe         = r_fe;
        n_new        = r_new;
        n_a          = r_a;
        n_pend       = r_pend;
        n_pend_v     = r_pend_v;
        n_o          = r_o;
        n_o_last     = r_o_last;
        n_o_valid    = 1'b0;
        n_iou_start  = 1'b0;

        cand_we    = 1'b0;
        cand_waddr = r_i[IW-1:0];
        cand_wdata = r_new;
        cand_raddr = r_i[IW-1:0];
        kept_we    = 1'b0;
        kept_waddr = r_kept[IW-1:0];
        kept_wdata = r_i[IW-1:0];
        kept_raddr = r_j[IW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_new.box.left   = i_left_edge;
                    n_new.box.top    = i_top_edge;
                    n_new.box.right  = i_right_edge;
                    n_new.box.bottom = i_bottom_edge;
                    n_new.score      = i_box_score;
                    n_new.number     = 12'(r_arrival);
                    n_arrival        = arr_next;
                    n_fe             = i_frame_end;
                    n_cand_count     = eff_n;
                    n_i              = '0;
                    n_kept           = '0;
                    if (i_box_score > r_score_thr && lim != '0) begin
                        if (eff_n < lim) begin
                            n_cand_count = eff_n + CW'(1);
                            n_i          = eff_n;
                            n_chk        = 1'b0;
                        end else begin
                            // full: tail entry decides whether the item gets in
                            n_i   = lim - CW'(1);
                            n_chk = 1'b1;
                        end
                        n_state = ST_INS_RD;
                    end else if (i_frame_end) begin
                        n_state = ST_SUP_RD;
                    end
                end
            end
            ST_INS_RD: begin
                if (!r_chk && r_i == '0) begin
                    cand_we = 1'b1;
                    n_i     = '0;
                    n_state = ins_done;
                end else begin
                    cand_raddr = r_chk ? r_i[IW-1:0] : ip[IW-1:0];
                    n_state    = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                if (r_chk) begin
                    if (cand_rd.score >= r_new.score) begin
                        n_i     = '0;
                        n_state = ins_done;
                    end else begin
                        n_chk   = 1'b0;
                        n_state = ST_INS_RD;
                    end
                end else if (cand_rd.score < r_new.score) begin
                    // move the entry above one place down
                    cand_we    = 1'b1;
                    cand_wdata = cand_rd;
                    n_i        = ip;
                    n_state    = ST_INS_RD;
                end else begin
                    cand_we = 1'b1;
                    n_i     = '0;
                    n_state = ins_done;
                end
            end
            ST_SUP_RD: begin
                if (r_i == r_cand_count) begin
                    n_q     = '0;
                    n_state = ST_OUT_RD;
                end else begin
                    n_state = ST_SUP_LD;
                end
            end
            ST_SUP_LD: begin
                n_a = cand_rd.box;
                n_j = '0;
                if (r_kept == '0) begin
                    kept_we = 1'b1;
                    n_kept  = r_kept + CW'(1);
                    n_i     = r_i + CW'(1);
                    n_state = ST_SUP_RD;
                end else begin
                    n_state = ST_KEEP_RD;
                end
            end
            ST_KEEP_RD: begin
                n_state = ST_SLOT_RD;
            end
            ST_SLOT_RD: begin
                cand_raddr  = kept_rd;
                n_iou_start = 1'b1;
                n_state     = ST_IOU_GO;
            end
            ST_IOU_GO: begin
                n_state = ST_IOU_WAIT;
            end
            ST_IOU_WAIT: begin
                if (iou_stat.done) begin
                    if (iou_stat.suppress) begin
                        n_i     = r_i + CW'(1);
                        n_state = ST_SUP_RD;
                    end else if (r_j + CW'(1) == r_kept) begin
                        kept_we = 1'b1;
                        n_kept  = r_kept + CW'(1);
                        n_i     = r_i + CW'(1);
                        n_state = ST_SUP_RD;
                    end else begin
                        n_j     = r_j + CW'(1);
                        n_state = ST_KEEP_RD;
                    end
                end
            end
            ST_OUT_RD: begin
                kept_raddr = r_q[IW-1:0];
                if (7'(r_q) == out_n) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_OUT_SLOT;
                end
            end
            ST_OUT_SLOT: begin
                cand_raddr = kept_rd;
                n_state    = ST_OUT_CALC;
            end
            ST_OUT_CALC: begin
                // one result is held back so the last can carry run_last
                if (cand_rd.score > r_report_thr) begin
                    if (r_pend_v) begin
                        n_o       = r_pend;
                        n_o_last  = 1'b0;
                        n_o_valid = 1'b1;
                    end
                    n_pend   = new_res;
                    n_pend_v = 1'b1;
                end
                n_q     = r_q + CW'(1);
                n_state = ST_OUT_RD;
            end
            ST_FIN: begin
                n_o          = r_pend_v ? r_pend : '0;
                n_o_last     = 1'b1;
                n_o_valid    = 1'b1;
                n_pend_v     = 1'b0;
                n_cand_count = '0;
                n_arrival    = '0;
                n_kept       = '0;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cand_count <= '0;
            r_arrival    <= '0;
            r_kept       <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_q          <= '0;
            r_chk        <= 1'b0;
            r_fe         <= 1'b0;
            r_pend_v     <= 1'b0;
            r_o_valid    <= 1'b0;
            r_iou_start  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cand_count <= n_cand_count;
            r_arrival    <= n_arrival;
            r_kept       <= n_kept;
            r_i          <= n_i;
            r_j          <= n_j;
            r_q          <= n_q;
            r_chk        <= n_chk;
            r_fe         <= n_fe;
            r_pend_v     <= n_pend_v;
            r_o_valid    <= n_o_valid;
            r_iou_start  <= n_iou_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new    <= n_new;
        r_a      <= n_a;
        r_pend   <= n_pend;
        r_o      <= n_o;
        r_o_last <= n_o_last;
    end

    assign o_valid      = r_o_valid;
    assign o_has_box    = r_o.has_box;
    assign o_box_number = r_o.number;
    assign o_out_left   = r_o.left;
    assign o_out_top    = r_o.top;
    assign o_out_right  = r_o.right;
    assign o_out_bottom = r_o.bottom;
    assign o_out_score  = r_o.score;
    assign o_run_last   = r_o_last;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_out_from_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == ST_OUT_CALC || $past(r_state) == ST_FIN))
        else $error("result shown outside the report phase");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cand_count <= CW'(MAX_CAND))
        else $error("candidate count beyond list depth");

    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_kept <= r_cand_count))
        else $error("more boxes kept than candidates");

    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |=> (!busy && o_valid && o_run_last))
        else $error("frame end did not close with a last result");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for box_non_max_suppression: directed table then random frames,
// results checked against a behavioural suppression predictor. Depends on bnms_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
    import bnms_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int N_RANDOM    = 150;
    localparam int ONE         = 65536;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [17:0] i_left_edge, i_top_edge, i_right_edge, i_bottom_edge;
    logic [15:0]        i_box_score;
    logic               i_frame_end;
    logic               o_valid, o_has_box, o_run_last;
    logic [11:0]        o_box_number;
    logic [15:0]        o_out_left, o_out_top, o_out_right, o_out_bottom, o_out_score;
    logic               psel, penable, pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    box_non_max_suppression uut (.*);

    // one line of stimulus; expect_empty marks a frame end whose only result is the
    // no-box result, known without the predictor
    typedef struct {
        t_box        box;
        logic [15:0] score;
        logic        last;
        logic        expect_empty;
    } t_row;

    typedef struct {
        t_result res;
        logic    last;
    } t_report;

    // predictor copy of registers and candidate list
    logic [15:0] thr_score, thr_overlap, thr_report;
    logic [6:0]  lim_cand, lim_keep;
    logic [11:0] reg_w, reg_h;
    t_cand       cand_list[64];
    int          cand_n;
    int          arrivals;

    t_report     pending_reports[$];
    int          reports_queued;
    int          mismatches;
    longint      cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // append an expected result and count it
    function automatic void add_report(input t_report r);
        pending_reports = {pending_reports, r};
        reports_queued++;
    endfunction

    // results cannot be held off: sample each strobe at the edge that ends it
    always @(posedge i_clk) begin
        t_report w;
        if (i_rst_n && o_valid) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected result, box", o_box_number, -1);
            end else begin
                w = pending_reports.pop_front();
                if (o_has_box !== w.res.has_box) report_mismatch("has_box", o_has_box, w.res.has_box);
                if (o_box_number !== w.res.number) report_mismatch("box_number", o_box_number, w.res.number);
                if (o_out_left !== w.res.left) report_mismatch("out_left", o_out_left, w.res.left);
                if (o_out_top !== w.res.top) report_mismatch("out_top", o_out_top, w.res.top);
                if (o_out_right !== w.res.right) report_mismatch("out_right", o_out_right, w.res.right);
                if (o_out_bottom !== w.res.bottom)
                    report_mismatch("out_bottom", o_out_bottom, w.res.bottom);
                if (o_out_score !== w.res.score) report_mismatch("out_score", o_out_score, w.res.score);
                if (o_run_last !== w.last) report_mismatch("run_last", o_run_last, w.last);
            end
        end
    end

    function automatic longint extent(input longint lo, input longint hi);
        return (hi > lo) ? hi - lo : 0;
    endfunction

    function automatic bit overlaps_too_much(input t_box a, input t_box b);
        longint a1, a2, inter, uni;
        a1 = extent(a.left, a.right) * extent(a.top, a.bottom);
        a2 = extent(b.left, b.right) * extent(b.top, b.bottom);
        inter = extent((a.left > b.left) ? a.left : b.left, (a.right < b.right) ? a.right : b.right)
              * extent((a.top > b.top) ? a.top : b.top, (a.bottom < b.bottom) ? a.bottom : b.bottom);
        uni = a1 + a2 - inter;
        return inter * 65536 > longint'(thr_overlap) * uni;
    endfunction

    function automatic logic [15:0] to_pixels(input longint c, input logic [11:0] size);
        longint v;
        if (c < 0) c = 0;
        if (c > ONE) c = ONE;
        v = (c * size + 2048) >>> 12;
        return v[15:0];
    endfunction

    // sorted insertion, and at frame end greedy suppression and report queueing
    task automatic predict_box(input t_box bx, input logic [15:0] sc, input logic last);
        int lim, p, top, kept_n, klim, produced;
        int kept[64];
        bit keep;
        t_report r;
        lim = (lim_cand >= 64) ? 64 : lim_cand;
        if (cand_n > lim) cand_n = lim;
        if (sc > thr_score) begin
            p = 0;
            while (p < cand_n && cand_list[p].score >= sc) p++;
            if (p < lim) begin
                top = (cand_n < lim) ? cand_n : lim - 1;
                for (int i = top; i > p; i--) cand_list[i] = cand_list[i-1];
                cand_list[p].box = bx;
                cand_list[p].score = sc;
                cand_list[p].number = arrivals[11:0];
                if (cand_n < lim) cand_n++;
            end
        end
        arrivals = (arrivals >= 4095) ? 0 : arrivals + 1;
        if (!last) return;
        kept_n = 0;
        for (int i = 0; i < cand_n; i++) begin
            keep = 1'b1;
            for (int j = 0; j < kept_n && keep; j++)
                if (overlaps_too_much(cand_list[i].box, cand_list[kept[j]].box)) keep = 1'b0;
            if (keep) kept[kept_n++] = i;
        end
        klim = (lim_keep >= 64) ? 64 : lim_keep;
        if (kept_n > klim) kept_n = klim;
        produced = 0;
        for (int i = 0; i < kept_n; i++) begin
            if (cand_list[kept[i]].score > thr_report) begin
                r.res.has_box = 1'b1;
                r.res.number = cand_list[kept[i]].number;
                r.res.left = to_pixels(cand_list[kept[i]].box.left, reg_w);
                r.res.top = to_pixels(cand_list[kept[i]].box.top, reg_h);
                r.res.right = to_pixels(cand_list[kept[i]].box.right, reg_w);
                r.res.bottom = to_pixels(cand_list[kept[i]].box.bottom, reg_h);
                r.res.score = cand_list[kept[i]].score;
                r.last = 1'b0;
                add_report(r);
                produced++;
            end
        end
        if (produced == 0) begin
            r = '{res: '0, last: 1'b0};
            add_report(r);
        end
        pending_reports[$].last = 1'b1;
        cand_n = 0;
        arrivals = 0;
    endtask

    // start drops only when a real gap follows, so back-to-back items keep it high
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
        if (n != 0) start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // block idle: everything expected has arrived, plus a margin for the sequencer
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_reports.size() != 0 || busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // one APB write; the bus is released by the caller after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_SCORE_THR:   thr_score = val;
            REG_OVERLAP_THR: thr_overlap = val;
            REG_CAND_LIMIT:  lim_cand = val[6:0];
            REG_KEEP_LIMIT:  lim_keep = val[6:0];
            REG_REPORT_THR:  thr_report = val;
            REG_REGION_W:    reg_w = val[11:0];
            default:         reg_h = val[11:0];
        endcase
    endtask

    task automatic configure(input logic [15:0] s, input logic [15:0] o, input logic [6:0] cl,
                             input logic [6:0] kl, input logic [15:0] r, input logic [11:0] w,
                             input logic [11:0] h);
        write_reg(REG_SCORE_THR, s);
        write_reg(REG_OVERLAP_THR, o);
        write_reg(REG_CAND_LIMIT, 16'(cl));
        write_reg(REG_KEEP_LIMIT, 16'(kl));
        write_reg(REG_REPORT_THR, r);
        write_reg(REG_REGION_W, 16'(w));
        write_reg(REG_REGION_H, 16'(h));
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // hand one item over; start is held until the edge that takes it
    task automatic send_box(input t_box bx, input logic [15:0] sc, input logic last);
        start <= 1'b1;
        i_left_edge <= bx.left; i_top_edge <= bx.top;
        i_right_edge <= bx.right; i_bottom_edge <= bx.bottom;
        i_box_score <= sc; i_frame_end <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_box(bx, sc, last);
    endtask

    // random box: mostly sensible and clustered so that overlaps happen, sometimes wild
    function automatic t_box random_box(input int cx, input int cy);
        t_box b;
        int w, h;
        if ($urandom_range(0, 7) == 0) begin
            b.left = 18'($urandom); b.top = 18'($urandom);
            b.right = 18'($urandom); b.bottom = 18'($urandom);
        end else begin
            w = $urandom_range(0, 40000);
            h = $urandom_range(0, 40000);
            b.left = 18'(cx - w / 2 + int'($urandom_range(0, 6000)) - 3000);
            b.top = 18'(cy - h / 2 + int'($urandom_range(0, 6000)) - 3000);
            b.right = 18'(int'(b.left) + w);
            b.bottom = 18'(int'(b.top) + h);
        end
        return b;
    endfunction

    t_row directed[$];

    function automatic void add_row(input t_row x);
        directed = {directed, x};
    endfunction

    function automatic t_row mk(input int l, input int t, input int r, input int b,
                                input int sc, input bit last, input bit empty);
        t_row x;
        x.box.left = 18'(l); x.box.top = 18'(t); x.box.right = 18'(r); x.box.bottom = 18'(b);
        x.score = 16'(sc); x.last = last; x.expect_empty = empty;
        return x;
    endfunction

    initial begin
        int frame_len, cx, cy;
        mismatches = 0; cycle_count = 0; reports_queued = 0;
        i_rst_n = 1'b0; start = 1'b0;
        i_left_edge = '0; i_top_edge = '0; i_right_edge = '0; i_bottom_edge = '0;
        i_box_score = '0; i_frame_end = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        thr_score = 16'd0; thr_overlap = 16'd29491; lim_cand = 7'd64; lim_keep = 7'd64;
        thr_report = 16'd0; reg_w = 12'd0; reg_h = 12'd0;
        cand_n = 0; arrivals = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: zero score never beats threshold zero, so the frame is empty
        add_row(mk(0, 0, 1000, 1000, 0, 1, 1));
        send_row_loop(0);

        configure(16'd0, 16'd29491, 7'd64, 7'd64, 16'd0, 12'd4095, 12'd4095);
        // extremes of coordinates and score, inverted box, clipping, ties, overlap
        add_row(mk(-131072, -131072, 131071, 131071, 65535, 0, 0));
        add_row(mk(131071, 131071, -131072, -131072, 65535, 0, 0));
        add_row(mk(0, 0, 65536, 65536, 1, 0, 0));
        add_row(mk(100, 100, 30000, 30000, 40000, 0, 0));
        add_row(mk(200, 200, 30100, 30100, 40000, 0, 0));
        add_row(mk(40000, 40000, 60000, 60000, 40000, 1, 0));
        add_row(mk(5, 5, 5, 5, 0, 1, 1));
        send_row_loop(1);

        // candidate and keep limits at zero give empty frames
        configure(16'd0, 16'd0, 7'd0, 7'd0, 16'd65535, 12'd0, 12'd0);
        add_row(mk(0, 0, 100, 100, 65535, 0, 0));
        add_row(mk(0, 0, 100, 100, 65535, 1, 1));
        send_row_loop(2);
        configure(16'd65535, 16'd65535, 7'd127, 7'd1, 16'd0, 12'd1, 12'd4095);
        add_row(mk(0, 0, 100, 100, 65535, 1, 1));
        send_row_loop(3);
        configure(16'd100, 16'd0, 7'd2, 7'd64, 16'd0, 12'd640, 12'd480);
        add_row(mk(0, 0, 100, 100, 5000, 0, 0));
        add_row(mk(10000, 0, 20000, 100, 6000, 0, 0));
        add_row(mk(30000, 0, 40000, 100, 7000, 0, 0));
        add_row(mk(50000, 0, 60000, 100, 50, 1, 0));
        send_row_loop(4);

        // random frames under several settings
        for (int n = 0; n < N_RANDOM; ) begin
            if ($urandom_range(0, 3) == 0 || n == 0) begin
                wait_drained();
                configure(16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000)),
                          16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(10000, 50000)),
                          7'($urandom_range(0, 1) ? 64 : $urandom_range(0, 70)),
                          7'($urandom_range(0, 1) ? 64 : $urandom_range(0, 70)),
                          16'($urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 3000)),
                          12'($urandom), 12'($urandom));
            end
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            cx = $urandom_range(0, 65536); cy = $urandom_range(0, 65536);
            for (int k = 0; k < frame_len; k++) begin
                idle_gap();
                send_box(random_box(cx, cy),
                         16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom),
                         k == frame_len - 1);
                n++;
            end
            if ($urandom_range(0, 9) == 0) wait_drained();
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_reports.size());
            $display("testbench failed");
        end
        $finish;
    end

    // walk the directed table; empty-frame rows carry their own typed-in result
    task automatic send_row_loop(input int phase);
        t_row row;
        int before_n;
        while (directed.size() != 0) begin
            row = directed.pop_front();
            before_n = reports_queued;
            send_box(row.box, row.score, row.last);
            if (row.expect_empty) begin
                if (reports_queued != before_n + 1 || pending_reports[$].res.has_box)
                    report_mismatch("directed empty frame, phase", phase, -1);
                pending_reports[$] = '{res: '0, last: 1'b1};
            end
            idle_gap();
        end
        wait_drained();
    endtask
endmodule
